// ===== src/atrlm_pkg.sv =====
package atrlm_pkg;

    // Request codes
    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Acknowledgement codes
    localparam logic [2:0] ACK_NONE  = 3'd0;
    localparam logic [2:0] ACK_OK    = 3'd1;
    localparam logic [2:0] ACK_ERROR = 3'd2;
    localparam logic [2:0] ACK_BUSY  = 3'd3;
    localparam logic [2:0] ACK_READY = 3'd4;

    localparam logic [7:0] LINE_FEED = 8'h0A;
    localparam logic [7:0] CARRIAGE  = 8'h0D;

    localparam int PATTERN_COUNT = 4;
    localparam int PATTERN_MAX   = 11;

    localparam logic [3:0] POSITION_MAX = 4'd15;

    typedef logic [0:PATTERN_COUNT-1][0:PATTERN_MAX-1][7:0] pattern_table_t;
    typedef logic [0:PATTERN_COUNT-1][3:0]                  pattern_len_t;
    typedef logic [PATTERN_COUNT-1:0]                       alive_t;

    localparam pattern_table_t ACK_PATTERNS = '{
        '{"O", "K", CARRIAGE, LINE_FEED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "R", "R", "O", "R", CARRIAGE, LINE_FEED, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "u", "s", "y", " ", "p", ".", ".", ".", CARRIAGE, LINE_FEED},
        '{"r", "e", "a", "d", "y", CARRIAGE, LINE_FEED, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam pattern_len_t ACK_LENGTHS = '{4'd4, 4'd7, 4'd11, 4'd7};

    // Expected character of pattern k at a line position; zero past the table
    function automatic logic [7:0] pattern_char(input logic [1:0] k, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (pos < 4'(PATTERN_MAX)) begin
            ch = ACK_PATTERNS[k][pos];
        end
        return ch;
    endfunction

endpackage

// ===== src/at_response_line_matcher.sv =====
// AT response line matcher: buffers modem bytes and flags OK / ERROR / busy / ready lines.
// Stages: A, then output register B. One request per cycle unless m_ready stalls;
// the store is a single-port-per-side RAM with one write and one registered read per
// cycle, and the line match state lives in flops.
// Reset (aresetn low, synchronous): fill count, line tracking, latched ack and the
// pipeline valids clear; the response store is not cleared.
module at_response_line_matcher #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_rx_byte,
    input  logic [9:0] s_read_index,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_ack_now,
    output logic [2:0] m_latched_ack,
    output logic [9:0] m_stored_length,
    output logic       m_dropped,
    output logic [7:0] m_read_data
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    // Width wide enough to compare a port index against the fill count
    localparam int CMP_W  = (ADDR_W > 10) ? ADDR_W : 10;
    localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(BUFFER_DEPTH - 1);

    // ------------------------------------------------------------------
    // Response store: written on each kept byte, read on each read request.
    // A write at one edge is visible to a read issued at any later edge,
    // and one request never reads and writes at once, so no forwarding.
    // ------------------------------------------------------------------
    logic [7:0]        mem [BUFFER_DEPTH];
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;

    // Line tracking and buffer state
    logic [ADDR_W-1:0]       fill_reg, fill_next;
    logic [3:0]              line_pos_reg, line_pos_next;
    atrlm_pkg::alive_t       alive_reg, alive_next;
    logic [2:0]              last_ack_reg, last_ack_next;

    // Stage A: request issued, read data on its way out of the RAM
    logic       a_valid_reg;
    logic [2:0] a_ack_now_reg, a_ack_now_next;
    logic [2:0] a_latched_reg;
    logic [9:0] a_length_reg;
    logic       a_dropped_reg, a_dropped_next;
    logic       a_hit_reg, a_hit_next;

    // Stage B: output register
    logic       b_valid_reg;
    logic [2:0] b_ack_now_reg;
    logic [2:0] b_latched_reg;
    logic [9:0] b_length_reg;
    logic       b_dropped_reg;
    logic [7:0] b_read_data_reg;

    logic accept;
    logic a_advance;

    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] fill_ext;
    logic [CMP_W-1:0] fill_next_ext;

    // Matcher for the incoming byte
    atrlm_pkg::alive_t match_alive;
    logic [2:0]        match_found;

    // Advance stage A whenever the output register frees up
    assign a_advance = !b_valid_reg || m_ready;
    assign s_ready   = !a_valid_reg || a_advance;
    assign accept    = s_valid && s_ready;

    assign idx_ext       = CMP_W'(s_read_index);
    assign fill_ext      = CMP_W'(fill_reg);
    assign fill_next_ext = CMP_W'(fill_next);
    assign rd_addr       = idx_ext[ADDR_W-1:0];

    // Per-pattern compare at the current line position
    always_comb begin
        match_alive = '0;
        match_found = atrlm_pkg::ACK_NONE;
        for (int k = 0; k < atrlm_pkg::PATTERN_COUNT; k++) begin
            if (alive_reg[k] && (line_pos_reg < atrlm_pkg::ACK_LENGTHS[k]) &&
                (atrlm_pkg::pattern_char(2'(k), line_pos_reg) == s_rx_byte)) begin
                match_alive[k] = 1'b1;
            end
        end
        // Lowest pattern wins; walk down so the last hit is the lowest
        if (s_rx_byte == atrlm_pkg::LINE_FEED) begin
            for (int k = atrlm_pkg::PATTERN_COUNT - 1; k >= 0; k--) begin
                if (match_alive[k] &&
                    (({1'b0, line_pos_reg} + 5'd1) == {1'b0, atrlm_pkg::ACK_LENGTHS[k]})) begin
                    match_found = 3'(k + 1);
                end
            end
        end
    end

    // Request decode and state update
    always_comb begin
        fill_next      = fill_reg;
        line_pos_next  = line_pos_reg;
        alive_next     = alive_reg;
        last_ack_next  = last_ack_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        a_ack_now_next = atrlm_pkg::ACK_NONE;
        a_dropped_next = 1'b0;
        a_hit_next     = 1'b0;
        if (accept) begin
            unique case (s_op)
                atrlm_pkg::OP_RX: begin
                    if (fill_reg < FILL_MAX) begin
                        mem_we         = 1'b1;
                        fill_next      = fill_reg + 1'b1;
                        a_ack_now_next = match_found;
                        if (s_rx_byte == atrlm_pkg::LINE_FEED) begin
                            // End of line: latch any hit, rearm every pattern
                            if (match_found != atrlm_pkg::ACK_NONE) begin
                                last_ack_next = match_found;
                            end
                            line_pos_next = '0;
                            alive_next    = '1;
                        end else begin
                            alive_next = match_alive;
                            if (line_pos_reg < atrlm_pkg::POSITION_MAX) begin
                                line_pos_next = line_pos_reg + 1'b1;
                            end
                        end
                    end else begin
                        // Store full: drop the byte, leave matching untouched
                        a_dropped_next = 1'b1;
                    end
                end
                atrlm_pkg::OP_RESTART: begin
                    fill_next     = '0;
                    line_pos_next = '0;
                    alive_next    = '1;
                    last_ack_next = atrlm_pkg::ACK_NONE;
                end
                atrlm_pkg::OP_READ: begin
                    mem_re     = 1'b1;
                    a_hit_next = (idx_ext < fill_ext);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[fill_reg] <= s_rx_byte;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // State and valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            line_pos_reg <= '0;
            alive_reg    <= '1;
            last_ack_reg <= atrlm_pkg::ACK_NONE;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            line_pos_reg <= line_pos_next;
            alive_reg    <= alive_next;
            last_ack_reg <= last_ack_next;
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (a_advance) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_ack_now_reg <= a_ack_now_next;
            a_latched_reg <= last_ack_next;
            a_length_reg  <= fill_next_ext[9:0];
            a_dropped_reg <= a_dropped_next;
            a_hit_reg     <= a_hit_next;
        end
        if (a_advance && a_valid_reg) begin
            b_ack_now_reg   <= a_ack_now_reg;
            b_latched_reg   <= a_latched_reg;
            b_length_reg    <= a_length_reg;
            b_dropped_reg   <= a_dropped_reg;
            b_read_data_reg <= a_hit_reg ? rd_data_reg : 8'h00;
        end
    end

    assign m_valid         = b_valid_reg;
    assign m_ack_now       = b_ack_now_reg;
    assign m_latched_ack   = b_latched_reg;
    assign m_stored_length = b_length_reg;
    assign m_dropped       = b_dropped_reg;
    assign m_read_data     = b_read_data_reg;

endmodule
